// File: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

   // Default channel width
   localparam int CHANNEL_BITS_DEF = 8;

   // Input field widths
   localparam int HUE_W = 15;
   localparam int COMP_W = 8;

   // Hue geometry in 1/64-degree units
   localparam int HUE_SECTOR = 3840;
   localparam int HUE_PERIOD = 7680;
   localparam int T_W = 12;

   // Intermediate product widths
   localparam int A_W = 20;   // s*t + (255-s)*3840
   localparam int BX_W = 28;  // v*a
   localparam int VZ_W = 16;  // v*(255-s)

   // Constant divisors of the three components
   localparam int unsigned DIV_C = 255;
   localparam int unsigned DIV_Z = 65025;
   localparam int unsigned DIV_X = 249696000;

   // Hue sector codes, named by the channels taking c then x
   typedef logic [2:0] sector_type;
   localparam sector_type SECTOR_RG = 3'd0;
   localparam sector_type SECTOR_GR = 3'd1;
   localparam sector_type SECTOR_GB = 3'd2;
   localparam sector_type SECTOR_BG = 3'd3;
   localparam sector_type SECTOR_BR = 3'd4;
   localparam sector_type SECTOR_RB = 3'd5;

endpackage

// File: rtl/hsvrgb_prep.sv
module hsvrgb_prep
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [HUE_W-1:0]                in_hue,
   input  logic [COMP_W-1:0]               in_sat,
   input  logic [COMP_W-1:0]               in_val,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [BX_W+CHANNEL_BITS-1:0]    out_num_x,
   output logic [VZ_W+CHANNEL_BITS-1:0]    out_num_z,
   output logic [COMP_W+CHANNEL_BITS-1:0]  out_num_c,
   output sector_type                      out_sector
);

   localparam int NX_W = BX_W + CHANNEL_BITS;
   localparam int NZ_W = VZ_W + CHANNEL_BITS;
   localparam int NC_W = COMP_W + CHANNEL_BITS;

   // Stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || out_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: hue sector and triangle position
   sector_type         sec1_in, sec1_ff;
   logic [T_W:0]       r1;
   logic [T_W-1:0]     t1_in, t1_ff;
   logic [COMP_W-1:0]  s1_ff, ns1_ff, v1d_ff;

   always_comb begin
      if (in_hue < HUE_W'(HUE_SECTOR)) begin
         sec1_in = SECTOR_RG;
      end else if (in_hue < HUE_W'(2 * HUE_SECTOR)) begin
         sec1_in = SECTOR_GR;
      end else if (in_hue < HUE_W'(3 * HUE_SECTOR)) begin
         sec1_in = SECTOR_GB;
      end else if (in_hue < HUE_W'(4 * HUE_SECTOR)) begin
         sec1_in = SECTOR_BG;
      end else if (in_hue < HUE_W'(5 * HUE_SECTOR)) begin
         sec1_in = SECTOR_BR;
      end else begin
         sec1_in = SECTOR_RB;
      end

      // hue mod period, hue below 4.3 periods
      if (in_hue >= HUE_W'(4 * HUE_PERIOD)) begin
         r1 = (T_W+1)'(in_hue - HUE_W'(4 * HUE_PERIOD));
      end else if (in_hue >= HUE_W'(3 * HUE_PERIOD)) begin
         r1 = (T_W+1)'(in_hue - HUE_W'(3 * HUE_PERIOD));
      end else if (in_hue >= HUE_W'(2 * HUE_PERIOD)) begin
         r1 = (T_W+1)'(in_hue - HUE_W'(2 * HUE_PERIOD));
      end else if (in_hue >= HUE_W'(HUE_PERIOD)) begin
         r1 = (T_W+1)'(in_hue - HUE_W'(HUE_PERIOD));
      end else begin
         r1 = (T_W+1)'(in_hue);
      end

      if (r1 >= (T_W+1)'(HUE_SECTOR)) begin
         t1_in = T_W'((T_W+1)'(HUE_PERIOD) - r1);
      end else begin
         t1_in = T_W'(r1);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         sec1_ff <= sec1_in;
         t1_ff <= t1_in;
         s1_ff <= in_sat;
         ns1_ff <= ~in_sat;
         v1d_ff <= in_val;
      end
   end

   // Stage 2: x weight numerator and zero-level product
   logic [A_W-1:0]     a2_in, a2_ff;
   logic [VZ_W-1:0]    vz2_in, vz2_ff;
   logic [COMP_W-1:0]  v2d_ff;
   sector_type         sec2_ff;

   always_comb begin
      a2_in = A_W'(s1_ff * t1_ff) + (A_W'(ns1_ff) << 12) - (A_W'(ns1_ff) << 8);
      vz2_in = v1d_ff * ns1_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         a2_ff <= a2_in;
         vz2_ff <= vz2_in;
         v2d_ff <= v1d_ff;
         sec2_ff <= sec1_ff;
      end
   end

   // Stage 3: v times x weight, full-scale for zero and c
   logic [BX_W-1:0]  bx3_in, bx3_ff;
   logic [NZ_W-1:0]  nz3_in, nz3_ff;
   logic [NC_W-1:0]  nc3_in, nc3_ff;
   sector_type       sec3_ff;

   always_comb begin
      bx3_in = BX_W'(v2d_ff * a2_ff);
      nz3_in = (NZ_W'(vz2_ff) << CHANNEL_BITS) - NZ_W'(vz2_ff);
      nc3_in = (NC_W'(v2d_ff) << CHANNEL_BITS) - NC_W'(v2d_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         bx3_ff <= bx3_in;
         nz3_ff <= nz3_in;
         nc3_ff <= nc3_in;
         sec3_ff <= sec2_ff;
      end
   end

   // Stage 4: full-scale for x
   logic [NX_W-1:0]  nx4_in, nx4_ff;
   logic [NZ_W-1:0]  nz4_ff;
   logic [NC_W-1:0]  nc4_ff;
   sector_type       sec4_ff;

   assign nx4_in = (NX_W'(bx3_ff) << CHANNEL_BITS) - NX_W'(bx3_ff);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         nx4_ff <= nx4_in;
         nz4_ff <= nz3_ff;
         nc4_ff <= nc3_ff;
         sec4_ff <= sec3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_num_x = nx4_ff;
   assign out_num_z = nz4_ff;
   assign out_num_c = nc4_ff;
   assign out_sector = sec4_ff;

endmodule

// File: rtl/hsvrgb_div_step.sv
module hsvrgb_div_step
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [BX_W+CHANNEL_BITS-1:0]    in_num_x,
   input  logic [VZ_W+CHANNEL_BITS-1:0]    in_num_z,
   input  logic [COMP_W+CHANNEL_BITS-1:0]  in_num_c,
   input  sector_type                      in_sector,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [CHANNEL_BITS-1:0]         out_quo_x,
   output logic [CHANNEL_BITS-1:0]         out_quo_z,
   output logic [CHANNEL_BITS-1:0]         out_quo_c,
   output sector_type                      out_sector
);

   localparam int NX_W = BX_W + CHANNEL_BITS;
   localparam int NZ_W = VZ_W + CHANNEL_BITS;
   localparam int NC_W = COMP_W + CHANNEL_BITS;
   localparam int Q1_W = CHANNEL_BITS + 1;
   localparam int PX_W = NX_W + Q1_W;
   localparam int PZ_W = NZ_W + Q1_W;
   localparam int PC_W = NC_W + Q1_W;

   // Reciprocals floor(2^W / D) for a W-bit numerator; estimate is low by at most one
   localparam logic [Q1_W-1:0] RCP_X = Q1_W'((64'd1 << NX_W) / 64'(DIV_X));
   localparam logic [Q1_W-1:0] RCP_Z = Q1_W'((64'd1 << NZ_W) / 64'(DIV_Z));
   localparam logic [Q1_W-1:0] RCP_C = Q1_W'((64'd1 << NC_W) / 64'(DIV_C));

   // Stage valids and enables
   logic v1_ff, v2_ff;
   logic rdy1, rdy2;

   assign rdy2 = !v2_ff || out_ready;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   // Stage 1: quotient estimate by reciprocal multiply
   logic [PX_W-1:0]          px1;
   logic [PZ_W-1:0]          pz1;
   logic [PC_W-1:0]          pc1;
   logic [CHANNEL_BITS-1:0]  ex1_in, ex1_ff, ez1_in, ez1_ff, ec1_in, ec1_ff;
   logic [NX_W-1:0]          nx1_ff;
   logic [NZ_W-1:0]          nz1_ff;
   logic [NC_W-1:0]          nc1_ff;
   sector_type               sec1_ff;

   always_comb begin
      px1 = PX_W'(in_num_x) * PX_W'(RCP_X);
      pz1 = PZ_W'(in_num_z) * PZ_W'(RCP_Z);
      pc1 = PC_W'(in_num_c) * PC_W'(RCP_C);
      ex1_in = px1[NX_W +: CHANNEL_BITS];
      ez1_in = pz1[NZ_W +: CHANNEL_BITS];
      ec1_in = pc1[NC_W +: CHANNEL_BITS];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ex1_ff <= ex1_in;
         ez1_ff <= ez1_in;
         ec1_ff <= ec1_in;
         nx1_ff <= in_num_x;
         nz1_ff <= in_num_z;
         nc1_ff <= in_num_c;
         sec1_ff <= in_sector;
      end
   end

   // Stage 2: bump the estimate when one more divisor still fits
   logic [Q1_W-1:0]          ux2, uz2, uc2;
   logic [PX_W-1:0]          mx2;
   logic [PZ_W-1:0]          mz2;
   logic [PC_W-1:0]          mc2;
   logic [CHANNEL_BITS-1:0]  qx2_in, qx2_ff, qz2_in, qz2_ff, qc2_in, qc2_ff;
   sector_type               sec2_ff;

   always_comb begin
      ux2 = Q1_W'(ex1_ff) + Q1_W'(1);
      uz2 = Q1_W'(ez1_ff) + Q1_W'(1);
      uc2 = Q1_W'(ec1_ff) + Q1_W'(1);
      mx2 = PX_W'(ux2) * PX_W'(DIV_X);
      mz2 = PZ_W'(uz2) * PZ_W'(DIV_Z);
      mc2 = PC_W'(uc2) * PC_W'(DIV_C);
      qx2_in = ex1_ff;
      if (PX_W'(nx1_ff) >= mx2) qx2_in = CHANNEL_BITS'(ux2);
      qz2_in = ez1_ff;
      if (PZ_W'(nz1_ff) >= mz2) qz2_in = CHANNEL_BITS'(uz2);
      qc2_in = ec1_ff;
      if (PC_W'(nc1_ff) >= mc2) qc2_in = CHANNEL_BITS'(uc2);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         qx2_ff <= qx2_in;
         qz2_ff <= qz2_in;
         qc2_ff <= qc2_in;
         sec2_ff <= sec1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_quo_x = qx2_ff;
   assign out_quo_z = qz2_ff;
   assign out_quo_c = qc2_ff;
   assign out_sector = sec2_ff;

endmodule

// File: rtl/hsvrgb_select.sv
module hsvrgb_select
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [CHANNEL_BITS-1:0]  in_comp_c,
   input  logic [CHANNEL_BITS-1:0]  in_comp_x,
   input  logic [CHANNEL_BITS-1:0]  in_comp_z,
   input  sector_type               in_sector,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [CHANNEL_BITS-1:0]  out_red,
   output logic [CHANNEL_BITS-1:0]  out_green,
   output logic [CHANNEL_BITS-1:0]  out_blue
);

   logic vld_ff;
   logic rdy;

   assign rdy = !vld_ff || out_ready;
   assign in_ready = rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (rdy) begin
         vld_ff <= in_valid;
      end
   end

   // Sector picks which channel takes c, x or zero level
   logic [CHANNEL_BITS-1:0] red_in, green_in, blue_in;
   logic [CHANNEL_BITS-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      case (in_sector)
         SECTOR_RG: begin
            red_in = in_comp_c; green_in = in_comp_x; blue_in = in_comp_z;
         end
         SECTOR_GR: begin
            red_in = in_comp_x; green_in = in_comp_c; blue_in = in_comp_z;
         end
         SECTOR_GB: begin
            red_in = in_comp_z; green_in = in_comp_c; blue_in = in_comp_x;
         end
         SECTOR_BG: begin
            red_in = in_comp_z; green_in = in_comp_x; blue_in = in_comp_c;
         end
         SECTOR_BR: begin
            red_in = in_comp_x; green_in = in_comp_z; blue_in = in_comp_c;
         end
         default: begin
            red_in = in_comp_c; green_in = in_comp_z; blue_in = in_comp_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy) begin
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_red = red_ff;
   assign out_green = green_ff;
   assign out_blue = blue_ff;

endmodule

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter, six-sector method.
// Request channel: req_hue (1/64 degree), req_saturation and req_brightness
// (code/255). A request is taken at a clock edge where req_valid is high and
// req_stall is low. Result channel: rsp_red, rsp_green, rsp_blue, each
// CHANNEL_BITS wide, taken when rsp_valid is high and rsp_stall is low.
// At any channel width the path runs through the hue decode and product
// stages, the constant divisions (reciprocal multiply, then a one-step
// correction) and one output register. Throughput is one pixel per cycle
// while rsp_stall is low; every stage carries its own valid bit.
// When the receiver stalls, the results hold and empty stages upstream keep
// filling, so req_stall rises only once the whole pipeline is full; nothing
// is lost or repeated. Synchronous reset clears all valid bits; no clearing
// pass is needed and a request can be taken in the first cycle after reset.
module hsv_to_rgb_converter_unit
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [HUE_W-1:0]         req_hue,
   input  logic [COMP_W-1:0]        req_saturation,
   input  logic [COMP_W-1:0]        req_brightness,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CHANNEL_BITS-1:0]  rsp_red,
   output logic [CHANNEL_BITS-1:0]  rsp_green,
   output logic [CHANNEL_BITS-1:0]  rsp_blue
);

   localparam int NX_W = BX_W + CHANNEL_BITS;
   localparam int NZ_W = VZ_W + CHANNEL_BITS;
   localparam int NC_W = COMP_W + CHANNEL_BITS;

   logic prep_ready;

   // Numerators from the product stages
   logic              div_valid;
   logic              div_ready;
   logic [NX_W-1:0]   num_x;
   logic [NZ_W-1:0]   num_z;
   logic [NC_W-1:0]   num_c;
   sector_type        div_sector;

   // Channel components after division
   logic                     sel_ready;
   logic                     sel_valid;
   logic [CHANNEL_BITS-1:0]  comp_x;
   logic [CHANNEL_BITS-1:0]  comp_z;
   logic [CHANNEL_BITS-1:0]  comp_c;
   sector_type               sel_sector;

   assign req_stall = !prep_ready;

   // Hue decode and products
   hsvrgb_prep #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (prep_ready),
      .in_hue     (req_hue),
      .in_sat     (req_saturation),
      .in_val     (req_brightness),
      .out_valid  (div_valid),
      .out_ready  (div_ready),
      .out_num_x  (num_x),
      .out_num_z  (num_z),
      .out_num_c  (num_c),
      .out_sector (div_sector)
   );

   // Constant divisions for the three components
   hsvrgb_div_step #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_num_x   (num_x),
      .in_num_z   (num_z),
      .in_num_c   (num_c),
      .in_sector  (div_sector),
      .out_valid  (sel_valid),
      .out_ready  (sel_ready),
      .out_quo_x  (comp_x),
      .out_quo_z  (comp_z),
      .out_quo_c  (comp_c),
      .out_sector (sel_sector)
   );

   // Channel routing and output register
   hsvrgb_select #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_comp_c (comp_c),
      .in_comp_x (comp_x),
      .in_comp_z (comp_z),
      .in_sector (sel_sector),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

// File: bench/hsv_to_rgb_converter_unit_test.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_test;
   import hsvrgb_pkg::*;

   localparam int CH_BITS = CHANNEL_BITS_DEF;
   localparam longint unsigned FULL = (64'd1 << CH_BITS) - 1;
   localparam int DIRECTED_ROWS = 22;
   localparam int NUM_PHASES = 5;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 30;

   typedef struct packed {
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [COMP_W-1:0] sat;
      logic [COMP_W-1:0] bri;
      logic              known;
      rgb_type           rgb;
   } pixel_row_type;

   // Directed pixels: primaries and secondaries, sector edges, hue past 360 degrees,
   // gray and black; expected colors typed in where they are obvious
   localparam pixel_row_type PIXEL_TABLE [DIRECTED_ROWS] = '{
      '{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{15'd23039, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd32767, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd135}},
      '{15'd12345, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{15'd5000,  8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd3839,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd1920,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd7679,  8'd1,   8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd11519, 8'd254, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd15359, 8'd77,  8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd19199, 8'd200, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd21000, 8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd16384, 8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd0,     8'd255, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{15'd7000,  8'd128, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}}
   };

   // Traffic phases: sender idle percent, receiver stall percent, pixels, long hold
   localparam int PHASE_IDLE [NUM_PHASES] = '{0, 88, 0, 18, 0};
   localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 88, 18, 0};
   localparam int PHASE_PIXELS [NUM_PHASES] = '{400, 300, 300, 480, 400};
   localparam bit PHASE_HOLD [NUM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HUE_W-1:0]    req_hue = '0;
   logic [COMP_W-1:0]   req_saturation = '0;
   logic [COMP_W-1:0]   req_brightness = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CH_BITS-1:0]  rsp_red;
   logic [CH_BITS-1:0]  rsp_green;
   logic [CH_BITS-1:0]  rsp_blue;

   rgb_type rgb_expected [$];
   rgb_type rgb_wanted;
   int   mismatch_count = 0;
   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_used = 1'b0;
   int   hold_left = 0;

   hsv_to_rgb_converter_unit #(
      .CHANNEL_BITS(CH_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_hue(req_hue),
      .req_saturation(req_saturation),
      .req_brightness(req_brightness),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Six-sector conversion, exact integer form truncated toward zero
   function automatic rgb_type hsv_to_rgb_predict(input logic [HUE_W-1:0] hue,
                                                  input logic [COMP_W-1:0] sat,
                                                  input logic [COMP_W-1:0] bri);
      longint unsigned h, s, v, phase, ramp, chroma, second, floor_lvl;
      longint unsigned band;
      logic [CH_BITS-1:0] c_bits, x_bits, z_bits;
      rgb_type px;
      h = 64'(hue);
      s = 64'(sat);
      v = 64'(bri);
      phase = h % HUE_PERIOD;
      ramp = (phase >= HUE_SECTOR) ? (HUE_PERIOD - phase) : phase;
      band = h / HUE_SECTOR;
      // hue at or past 360 degrees stays in the last band
      if (band > SECTOR_RB) band = 64'(SECTOR_RB);
      chroma = (v * FULL) / DIV_C;
      floor_lvl = (v * (255 - s) * FULL) / DIV_Z;
      second = (v * (s * ramp + (255 - s) * HUE_SECTOR) * FULL) / DIV_X;
      c_bits = CH_BITS'(chroma);
      x_bits = CH_BITS'(second);
      z_bits = CH_BITS'(floor_lvl);
      case (sector_type'(band))
         SECTOR_RG: px = '{c_bits, x_bits, z_bits};
         SECTOR_GR: px = '{x_bits, c_bits, z_bits};
         SECTOR_GB: px = '{z_bits, c_bits, x_bits};
         SECTOR_BG: px = '{z_bits, x_bits, c_bits};
         SECTOR_BR: px = '{x_bits, z_bits, c_bits};
         default:   px = '{c_bits, z_bits, x_bits};
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 30) $display("%0t ns: %s", $time, what);
   endtask

   // Offer one pixel, with random idle cycles ahead of it; record its color on acceptance
   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [COMP_W-1:0] sat,
                             input logic [COMP_W-1:0] bri, input rgb_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      do @(posedge clock); while (req_stall);
      rgb_expected.push_back(want);
   endtask

   // Receiver: random stall, plus one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Result check against the oldest outstanding request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rgb_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                      rsp_red, rsp_green, rsp_blue));
         end else begin
            rgb_wanted = rgb_expected.pop_front();
            if (rsp_red !== rgb_wanted.red)
               report_mismatch($sformatf("red %0d, expected %0d", rsp_red, rgb_wanted.red));
            if (rsp_green !== rgb_wanted.green)
               report_mismatch($sformatf("green %0d, expected %0d",
                                         rsp_green, rgb_wanted.green));
            if (rsp_blue !== rgb_wanted.blue)
               report_mismatch($sformatf("blue %0d, expected %0d", rsp_blue, rgb_wanted.blue));
         end
      end
   end

   initial begin
      int row, ph, n, mode, drain;
      logic [HUE_W-1:0]  hue;
      logic [COMP_W-1:0] sat, bri;
      pixel_row_type pix;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed pixels
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         pix = PIXEL_TABLE[row];
         send_pixel(pix.hue, pix.sat, pix.bri,
                    pix.known ? pix.rgb : hsv_to_rgb_predict(pix.hue, pix.sat, pix.bri));
      end

      // random pixels under each traffic pattern
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         sender_idle_pct = PHASE_IDLE[ph];
         receiver_stall_pct <= PHASE_STALL[ph];
         if (PHASE_HOLD[ph]) hold_req <= 1'b1;
         for (n = 0; n < PHASE_PIXELS[ph]; n++) begin
            mode = $urandom_range(19);
            if (mode == 0) hue = HUE_W'($urandom_range(32767, 23040));
            else if (mode < 4)
               hue = HUE_W'(HUE_SECTOR * $urandom_range(6) + $urandom_range(2) - 1);
            else hue = HUE_W'($urandom_range(23039));
            mode = $urandom_range(7);
            sat = (mode == 0) ? 8'd0 : (mode == 1) ? 8'd255 : 8'($urandom_range(255));
            mode = $urandom_range(7);
            bri = (mode == 0) ? 8'd0 : (mode == 1) ? 8'd255 : 8'($urandom_range(255));
            send_pixel(hue, sat, bri, hsv_to_rgb_predict(hue, sat, bri));
         end
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the pipeline settle
      drain = 0;
      while (rgb_expected.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rgb_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", rgb_expected.size()));

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule
